// File: hdl/lfuab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuab_pkg: shared types and constants of the LFU cache directory
// Command and status groups between controller and datapath, reset values of
// the aging registers and the fixed stream field widths.
// ----------------------------------------------------------------------------
package lfuab_pkg;

  localparam int IN_KEY_W     = 40;
  localparam int OUT_SLOT_W   = 8;
  localparam int OUT_KEY_W    = 40;
  localparam int OUT_TDATA_W  = 56;
  localparam int CFG_W        = 8;

  localparam logic [CFG_W-1:0] AGING_PERIOD_RESET = 8'd20;
  localparam logic [CFG_W-1:0] MISS_PHASE_RESET   = 8'd19;

  typedef struct packed {
    logic start;   // load the request key and restart the scan
    logic scan;    // scan in progress, issue the next directory read
    logic commit;  // apply the update and load the result register
  } lfuab_cmd_t;

  typedef struct packed {
    logic scan_done;  // all slots have been evaluated
    logic out_free;   // result register can take a new result
  } lfuab_status_t;

endpackage

// File: hdl/lfuab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuab_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfuab_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lfuab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuab_ctrl: request sequencer of the LFU cache directory
// Accepts a request, runs the directory scan and commits the update once the
// result register is free.
// ----------------------------------------------------------------------------
module lfuab_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  lfuab_pkg::lfuab_status_t status,
  output lfuab_pkg::lfuab_cmd_t    cmd
);
  import lfuab_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/lfuab_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuab_dp: datapath of the LFU cache directory
// Slot store, scan for match and minimum, aging registers and result register.
// ----------------------------------------------------------------------------
module lfuab_dp #(
  parameter int NUM_SLOTS  = 256,
  parameter int KEY_BITS   = 40,
  parameter int COUNT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [lfuab_pkg::IN_KEY_W-1:0]       in_key,
  input  logic                                 cfg_wr_en,
  input  logic [lfuab_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [lfuab_pkg::OUT_SLOT_W-1:0]     out_slot,
  output logic                                 out_evicted,
  output logic [lfuab_pkg::OUT_KEY_W-1:0]      out_evicted_key,
  input  lfuab_pkg::lfuab_cmd_t                cmd,
  output lfuab_pkg::lfuab_status_t             status
);
  import lfuab_pkg::*;

  localparam int IDXW = $clog2(NUM_SLOTS);
  localparam int OCCW = $clog2(NUM_SLOTS + 1);
  localparam int ENTW = KEY_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [IDXW-1:0]       LAST_IDX  = IDXW'(NUM_SLOTS - 1);
  localparam logic [OCCW-1:0]       FULL_OCC  = OCCW'(NUM_SLOTS);

  // Request key and scan bookkeeping.
  logic [KEY_BITS-1:0]   key_r;
  logic [IDXW-1:0]       rd_addr_r;
  logic                  issue_r;
  logic                  pv_r;
  logic [IDXW-1:0]       pidx_r;
  logic                  done_r;
  logic                  found_r;
  logic [IDXW-1:0]       match_idx_r;
  logic [COUNT_BITS-1:0] match_cnt_r;
  logic [IDXW-1:0]       min_idx_r;
  logic [COUNT_BITS-1:0] min_cnt_r;
  logic [KEY_BITS-1:0]   min_key_r;

  // Directory-wide state.
  logic [OCCW-1:0]       occ_r;
  logic [COUNT_BITS-1:0] ins_r;
  logic [CFG_W-1:0]      phase_r;
  logic [CFG_W-1:0]      period_r;

  // Result register.
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic                  out_ev_r;
  logic [OUT_KEY_W-1:0]  out_evkey_r;

  logic [ENTW-1:0]       rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  rd_live;
  logic [COUNT_BITS-1:0] eff_cnt;
  logic [63:0]           in_ext;
  logic [63:0]           evkey_ext;
  logic [IDXW+7:0]       slot_ext;

  logic [IDXW-1:0]       x_idx;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS-1:0] ins_nxt;
  logic [CFG_W-1:0]      phase_nxt;
  logic [CFG_W-1:0]      phase_inc;
  logic [OCCW-1:0]       occ_nxt;
  logic                  ev_nxt;
  logic                  full;

  lfuab_ram #(
    .WIDTH (ENTW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (x_idx),
    .wdata ({key_r, new_cnt}),
    .re    (cmd.scan && issue_r),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  assign rd_key  = rdata[ENTW-1:COUNT_BITS];
  assign rd_cnt  = rdata[COUNT_BITS-1:0];
  // Slots fill strictly in index order and never free up, so the fill count
  // tells which entries hold data.
  assign rd_live = OCCW'(pidx_r) < occ_r;
  assign eff_cnt = rd_live ? rd_cnt : '0;
  assign in_ext  = {{(64 - IN_KEY_W){1'b0}}, in_key};
  assign full    = occ_r == FULL_OCC;

  always_comb begin
    x_idx     = min_idx_r;
    new_cnt   = ins_r;
    ins_nxt   = ins_r;
    phase_nxt = phase_r;
    phase_inc = phase_r + 1'b1;
    occ_nxt   = occ_r;
    ev_nxt    = 1'b0;
    priority if (found_r) begin
      x_idx   = match_idx_r;
      new_cnt = (match_cnt_r == COUNT_MAX) ? match_cnt_r : match_cnt_r + 1'b1;
    end else if (!full) begin
      x_idx   = occ_r[IDXW-1:0];
      occ_nxt = occ_r + 1'b1;
    end else begin
      ev_nxt = 1'b1;
      if (phase_inc >= period_r) begin
        phase_nxt = '0;
        if (ins_r != COUNT_MAX) begin
          ins_nxt = ins_r + 1'b1;
        end
      end else begin
        phase_nxt = phase_inc;
      end
      new_cnt = ins_nxt;
    end
  end

  assign evkey_ext = 64'(min_key_r);
  assign slot_ext  = {8'b0, x_idx};

  // Scan and result payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_ext[KEY_BITS-1:0];
    end
    if (pv_r) begin
      if (rd_live && !found_r && rd_key == key_r) begin
        match_idx_r <= pidx_r;
        match_cnt_r <= rd_cnt;
      end
      if (pidx_r == '0 || eff_cnt < min_cnt_r) begin
        min_idx_r <= pidx_r;
        min_cnt_r <= eff_cnt;
        min_key_r <= rd_key;
      end
    end
    if (cmd.scan && issue_r) begin
      pidx_r <= rd_addr_r;
    end
    if (cmd.commit) begin
      out_hit_r   <= found_r;
      out_slot_r  <= slot_ext[7:0];
      out_ev_r    <= ev_nxt;
      out_evkey_r <= ev_nxt ? evkey_ext[OUT_KEY_W-1:0] : '0;
    end
  end

  // Control and directory state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r   <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
      done_r      <= 1'b0;
      found_r     <= 1'b0;
      occ_r       <= '0;
      ins_r       <= COUNT_BITS'(1);
      phase_r     <= MISS_PHASE_RESET;
      period_r    <= AGING_PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        rd_addr_r <= '0;
        issue_r   <= 1'b1;
        pv_r      <= 1'b0;
        done_r    <= 1'b0;
        found_r   <= 1'b0;
      end else begin
        if (cmd.scan && issue_r) begin
          rd_addr_r <= rd_addr_r + 1'b1;
          if (rd_addr_r == LAST_IDX) begin
            issue_r <= 1'b0;
          end
        end
        pv_r <= cmd.scan && issue_r;
        if (pv_r) begin
          if (rd_live && rd_key == key_r) begin
            found_r <= 1'b1;
          end
          if (pidx_r == LAST_IDX) begin
            done_r <= 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        occ_r   <= occ_nxt;
        ins_r   <= ins_nxt;
        phase_r <= phase_nxt;
        done_r  <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.scan_done = done_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evkey_r;

endmodule

// File: hdl/lfu_aging_block_cache_policy.sv
`timescale 1ns / 1ps
// A request is accepted while the block is idle, the directory is scanned, and
//   the update is committed; the commit waits only while the previous result
//   is still waiting at the output. A new request is taken only after that
//   commit. The scan reads one slot of the directory RAM per cycle and is
//   followed by the registered read, the update state and the commit.
// Reset: synchronous, active-low rst_n; every slot reads as free, insertion
//   value one, aging period 20, miss phase 19. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lfu_aging_block_cache_policy: LFU cache directory with insertion aging
// Fully associative directory that reports hit, slot and eviction for each
// block key, replacing the least frequently used slot when full.
// ----------------------------------------------------------------------------
module lfu_aging_block_cache_policy #(
  parameter int NUM_SLOTS  = 256,
  parameter int KEY_BITS   = 40,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: block_key[39:0]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lfuab_pkg::IN_KEY_W-1:0]      in_tdata,
  // out_tdata: hit[0], slot[8:1], evicted[9], evicted_key[49:10], zero[55:50]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lfuab_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [lfuab_pkg::CFG_W-1:0]         cfg_wr_data
);
  import lfuab_pkg::*;

  // The controller walks each request through three phases: it accepts the
  // key, lets the datapath scan every slot once, and then commits the update
  // as soon as the result register can take the new result.
  lfuab_cmd_t    cmd;
  lfuab_status_t status;

  logic                  res_hit;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic                  res_evicted;
  logic [OUT_KEY_W-1:0]  res_evkey;

  lfuab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the slot RAM (key and use count side by side), the
  // scan registers that track the first match and the first minimum, the
  // fill count, the aging registers and the output register. Because slots
  // are filled strictly in index order and never freed, the fill count alone
  // decides which entries are live, so the RAM itself is never cleared.
  lfuab_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key          (in_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_hit         (res_hit),
    .out_slot        (res_slot),
    .out_evicted     (res_evicted),
    .out_evicted_key (res_evkey),
    .cmd             (cmd),
    .status          (status)
  );

  // Pack the result fields from the lowest bit up, padded to whole bytes.
  assign out_tdata = {{(OUT_TDATA_W - OUT_KEY_W - OUT_SLOT_W - 2){1'b0}},
                      res_evkey, res_evicted, res_slot, res_hit};

`ifndef SYNTH
  // An update is committed only when the result register can take it.
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("update committed while the result register was occupied");

  // A commit always presents a result in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed request produced no result");

  // Once a request is taken, no other is accepted until its scan has run.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted during a scan");

  // A scan result is never used before the directory walk has finished.
  a_done_before_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.scan_done)
    else $error("commit issued before the scan completed");
`endif

endmodule

// File: tb/lfu_aging_block_cache_policy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_aging_block_cache_policy_tb: self-checking bench for the LFU directory
// Streams block keys into the directory and checks every hit/slot/eviction
// report against a cycle-free LFU directory model with insertion aging. The
// run walks through an empty cache, the fill to full occupancy, and eviction
// under several aging periods, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lfu_aging_block_cache_policy_tb;
  import lfuab_pkg::*;

  localparam int NUM_SLOTS   = 256;
  localparam int COUNT_BITS  = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int EVICT_POOL  = 32;

  // One expected access report, in the order the fields leave the block.
  typedef struct packed {
    logic                 hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                 evicted;
    logic [OUT_KEY_W-1:0] evicted_key;
  } access_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_KEY_W-1:0]    in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  lfu_aging_block_cache_policy uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Directory model. It mirrors the block's architectural state: per-slot use
  // counts (zero means free) and keys, the insertion count value, the miss
  // phase of the aging counter, the number of occupied slots and the period.
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] dir_count [NUM_SLOTS];
  logic [IN_KEY_W-1:0]   dir_key   [NUM_SLOTS];
  logic [COUNT_BITS-1:0] insert_level = 1;
  logic [7:0]            miss_phase   = MISS_PHASE_RESET;
  logic [CFG_W-1:0]      aging_period = AGING_PERIOD_RESET;
  int                    occupancy    = 0;

  access_report_t        pending_reports[$];
  logic [IN_KEY_W-1:0]   evicted_pool[$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      dir_count[i] = '0;
      dir_key[i]   = '0;
    end
  end

  // Applies one request to the directory model and returns what the block
  // must report for it. A single pass finds the first tag match among the
  // occupied slots, the first free slot, and the first slot of least count.
  function automatic access_report_t lookup_and_update(input logic [IN_KEY_W-1:0] key);
    access_report_t rep;
    int             match_idx;
    int             free_idx;
    int             min_idx;
    int             x;
    bit             found;
    bit             have_free;
    logic [7:0]     next_phase;
    rep       = '0;
    match_idx = 0;
    free_idx  = 0;
    min_idx   = 0;
    found     = 1'b0;
    have_free = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (dir_count[i] != '0) begin
        if (!found && dir_key[i] == key) begin
          found     = 1'b1;
          match_idx = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
      if (dir_count[i] < dir_count[min_idx]) min_idx = i;
    end

    if (found) begin
      x       = match_idx;
      rep.hit = 1'b1;
      // Use counts saturate at all ones.
      if (dir_count[x] != '1) dir_count[x] = dir_count[x] + 1'b1;
    end else begin
      if (occupancy < NUM_SLOTS) begin
        x = have_free ? free_idx : 0;
        occupancy++;
      end else begin
        // Full-cache miss: advance the aging phase. A phase at or past the
        // period (including a period lowered below it, or a period of zero)
        // wraps to zero and raises the insertion value.
        next_phase = miss_phase + 8'd1;
        if (next_phase >= aging_period) begin
          next_phase = '0;
          if (insert_level != '1) insert_level = insert_level + 1'b1;
        end
        miss_phase      = next_phase;
        x               = min_idx;
        rep.evicted     = 1'b1;
        rep.evicted_key = dir_key[x];
        evicted_pool.push_back(dir_key[x]);
        if (evicted_pool.size() > EVICT_POOL) void'(evicted_pool.pop_front());
      end
      dir_count[x] = insert_level;
      dir_key[x]   = key;
    end
    rep.slot = x[OUT_SLOT_W-1:0];
    return rep;
  endfunction

  // Chooses the next key: a cached key with the given chance (low slots are
  // favored so that use counts spread unevenly), now and then a key that was
  // recently evicted, and otherwise a fresh random key.
  function automatic logic [IN_KEY_W-1:0] choose_key(input int hit_pct);
    int          s;
    logic [63:0] wide;
    if (occupancy > 0 && $urandom_range(0, 99) < hit_pct) begin
      s = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, NUM_SLOTS - 1);
      if (dir_count[s] != '0) return dir_key[s];
    end
    if (evicted_pool.size() > 0 && $urandom_range(0, 9) == 0)
      return evicted_pool[$urandom_range(0, evicted_pool.size() - 1)];
    wide = {$urandom(), $urandom()};
    return wide[IN_KEY_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Request side. The sender works in bursts; between bursts tvalid drops for
  // a random gap, sometimes long enough to land anywhere in the block's scan.
  // tvalid is left high after an accepted request so that a following
  // request in the same burst goes out without a bubble.
  // --------------------------------------------------------------------------
  task automatic send_key(input logic [IN_KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_reports.push_back(lookup_and_update(key));
    burst_left--;
  endtask

  // Holds the sender off until every outstanding request has been reported.
  // Every request yields exactly one report, so an empty queue means idle.
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the aging period while the block is idle.
  task automatic write_aging_period(input logic [CFG_W-1:0] period);
    cfg_wr_data <= period;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    aging_period  = period;
  endtask

  task automatic send_random(input int count, input int hit_pct);
    repeat (count) send_key(choose_key(hit_pct));
  endtask

  // --------------------------------------------------------------------------
  // Result side. The receiver changes its stall pattern at the start of each
  // window: always ready, mostly ready, mostly stalled, a short periodic pattern,
  // or a single ready cycle per window so that a report sits at the output while
  // the next request is already being scanned.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : report_checker
    int             sink_mode;
    access_report_t want;
    logic [5:0]     pad;
    if (cycle_count[8:0] == 9'd0) sink_mode = $urandom_range(0, 4);
    case (sink_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_tready <= ($urandom_range(0, 3) == 0);
      end
      3: begin
        out_tready <= (cycle_count[2:0] == 3'd0);
      end
      default: begin
        out_tready <= (cycle_count[8:0] == 9'h1ff);
      end
    endcase

    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: tdata %h with no request outstanding", out_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        pad  = out_tdata[55:50];
        if (out_tdata[0] !== want.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", want.hit, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[8:1] !== want.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", want.slot, out_tdata[8:1]);
          error_count++;
        end
        if (out_tdata[9] !== want.evicted) begin
          $error("evicted mismatch: expected %0d, actual %0d", want.evicted, out_tdata[9]);
          error_count++;
        end
        if (out_tdata[49:10] !== want.evicted_key) begin
          $error("evicted_key mismatch: expected %h, actual %h",
                 want.evicted_key, out_tdata[49:10]);
          error_count++;
        end
        if (pad !== 6'd0) begin
          $error("pad mismatch: expected 0, actual %h", pad);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL lfu_aging_block_cache_policy");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty cache with the reset period: key zero must miss although every
  // model key is zero after reset, the key extremes are inserted and hit
  // again, and alternating-bit, single-bit and near-match keys test the tag compare.
  task automatic test_empty_cache_directed();
    send_key(40'h00_0000_0000);
    send_key(40'h00_0000_0000);
    send_key(40'hFF_FFFF_FFFF);
    send_key(40'hFF_FFFF_FFFF);
    send_key(40'hFF_FFFF_FFFF);
    send_key(40'h55_5555_5555);
    send_key(40'hAA_AAAA_AAAA);
    send_key(40'h80_0000_0000);
    send_key(40'h00_0000_0001);
    send_key(40'h00_0000_0000);
    send_key(40'h55_5555_5554);
    wait_for_idle();
  endtask

  // Mostly new keys until every slot is taken, with some hits in between.
  task automatic test_fill_to_capacity();
    while (occupancy < NUM_SLOTS) send_key(choose_key(10));
    wait_for_idle();
  endtask

  // First evictions: a fresh key replaces the least used slot, the key just
  // evicted comes back as a miss, and freshly inserted keys hit.
  task automatic test_eviction_directed();
    logic [IN_KEY_W-1:0] fresh_a;
    logic [IN_KEY_W-1:0] fresh_b;
    fresh_a = 40'h12_3456_789A;
    fresh_b = 40'hED_CBA9_8765;
    send_key(fresh_a);
    send_key(evicted_pool[evicted_pool.size() - 1]);
    send_key(fresh_a);
    send_key(fresh_b);
    send_key(fresh_b);
    wait_for_idle();
  endtask

  // Period of one: every full-cache miss raises the insertion value.
  task automatic test_period_min();
    write_aging_period(8'd1);
    send_random(30, 50);
    wait_for_idle();
  endtask

  // Largest period: the phase climbs without wrapping for this stretch.
  task automatic test_period_max();
    write_aging_period(8'd255);
    send_random(30, 50);
    wait_for_idle();
  endtask

  // The period is lowered below the phase reached above, so the next
  // full-cache miss wraps the phase at once.
  task automatic test_period_below_phase();
    write_aging_period(8'd3);
    send_random(20, 50);
    wait_for_idle();
  endtask

  // Period of zero behaves like a period of one.
  task automatic test_period_zero();
    write_aging_period(8'd0);
    send_random(20, 50);
    wait_for_idle();
  endtask

  // Back to the reset period for a longer stretch of mixed traffic.
  task automatic test_period_reset_value();
    write_aging_period(AGING_PERIOD_RESET);
    send_random(40, 50);
    wait_for_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_cache_directed();
    test_fill_to_capacity();
    test_eviction_directed();
    test_period_min();
    test_period_max();
    test_period_below_phase();
    test_period_zero();
    test_period_reset_value();

    // Let a full scan pass to catch any stray report.
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS lfu_aging_block_cache_policy");
    end else begin
      $display("FAIL lfu_aging_block_cache_policy");
    end
    $finish;
  end

endmodule
